[design/i2da_pkg.sv]
// Shared types and constants for the integer to decimal ASCII converter.
`default_nettype none

package i2da_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned CharW  = 6;

  // ASCII codes truncated to the 6-bit character field
  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  // Per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clr;    // clear digit to zero
    logic dab;    // shift-add-3 step, take one magnitude bit from the neighbor
    logic shift;  // move whole digit toward the most significant end
  } i2da_cell_ctrl_t;

endpackage

`default_nettype wire

[design/i2da_if.sv]
// Valid/ready channel interfaces for integer input and character output.
`default_nettype none

interface i2da_in_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2da_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

[design/i2da_cell.sv]
// One BCD digit cell of the shift-add-3 converter chain.
`default_nettype none

module i2da_cell import i2da_pkg::*; (
  input  wire logic              clk_i,
  input  wire i2da_cell_ctrl_t   ctrl_i,
  input  wire logic              bit_i,
  input  wire logic [DigitW-1:0] digit_i,
  output logic                   bit_o,
  output logic [DigitW-1:0]      digit_o
);

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] adj;

  // Correct before doubling so the digit never exceeds nine
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o   = adj[DigitW-1];
  assign digit_o = digit_q;

  always_comb begin
    priority if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.dab) begin
      digit_d = {adj[DigitW-2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

[design/int_to_decimal_ascii_core.sv]
// Top level: signed integer to decimal ASCII text, sent one character per output transfer.
//
//   channel | dir | payload
//   in_i    | in  | value (VALUE_WIDTH bits, signed)
//   out_o   | out | text_char (6 bits), last_char (1 bit)
//
// Each integer is accepted, converted through the digit cell chain (one magnitude
// bit per cycle), has its leading zero digits skipped, and is then sent one
// character at a time, a minus sign first for a negative value.
// A new integer is taken once the last character sits in the output register.
// Reset clears the control state and the output valid; digits need none.
// A stalled output holds the character and freezes the emit sequence.
`default_nettype none

module int_to_decimal_ascii_core import i2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2da_in_if.sink    in_i,
  i2da_out_if.source out_o
);

  // Digits needed for a magnitude up to 2^(VALUE_WIDTH-1)
  localparam int unsigned Nd   = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RemW = $clog2(Nd + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   sign_q, sign_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic                   ovalid_q, ovalid_d;
  logic [CharW-1:0]       char_q, char_d;
  logic                   last_q, last_d;

  i2da_cell_ctrl_t        ctrl;
  logic [Nd:0]            bit_chain;
  logic [Nd-1:0][DigitW-1:0] digits;
  logic [DigitW-1:0]      top_digit;
  logic                   slot_free;
  logic                   in_acc;
  logic [VALUE_WIDTH-1:0] raw;

  assign raw       = in_i.value;
  assign in_i.ready = (state_q == StIdle);
  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !ovalid_q || out_o.ready;
  assign top_digit = digits[Nd-1];

  // Magnitude enters the least significant cell, most significant bit first
  assign bit_chain[0] = mag_q[VALUE_WIDTH-1];

  for (genvar i = 0; i < Nd; i++) begin : g_cell
    logic [DigitW-1:0] din;
    if (i == 0) begin : g_first
      assign din = '0;
    end else begin : g_rest
      assign din = digits[i-1];
    end
    i2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (bit_chain[i]),
      .digit_i (din),
      .bit_o   (bit_chain[i+1]),
      .digit_o (digits[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    sign_d   = sign_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    ctrl     = '0;

    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          sign_d  = raw[VALUE_WIDTH-1];
          mag_d   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          cnt_d   = CntW'(VALUE_WIDTH);
          ctrl.clr = 1'b1;
          state_d = StConv;
        end
      end
      StConv: begin
        ctrl.dab = 1'b1;
        mag_d    = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          rem_d   = RemW'(Nd);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zeros, but keep the last digit so zero prints '0'
        if (top_digit == '0 && rem_q != RemW'(1)) begin
          ctrl.shift = 1'b1;
          rem_d      = rem_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          if (sign_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d     = CharZero + CharW'(top_digit);
            last_d     = (rem_q == RemW'(1));
            ctrl.shift = 1'b1;
            rem_d      = rem_q - 1'b1;
            if (rem_q == RemW'(1)) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      sign_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      sign_q   <= sign_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;

endmodule

`default_nettype wire

[tb/decimal_text_monitor.sv]
// Monitor that predicts the decimal text of each accepted integer and checks the characters.
`timescale 1ns / 100ps

module decimal_text_monitor import i2da_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2da_in_if          in_i,
  i2da_out_if         out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef struct {
    logic [CharW-1:0] text_char;
    logic             last_char;
  } text_char_t;

  text_char_t  expected_text[$];
  int unsigned mismatches;

  // Append the characters of one integer, most significant first
  function automatic void push_decimal_text(input logic signed [31:0] value);
    logic [32:0]      magnitude;
    logic             negative;
    logic [DigitW-1:0] digits[0:9];
    int               num_digits;
    text_char_t       ch;
    negative   = value[31];
    magnitude  = negative ? (33'd0 - {value[31], value}) : {1'b0, value};
    num_digits = 0;
    do begin
      digits[num_digits] = DigitW'(magnitude % 33'd10);
      magnitude          = magnitude / 33'd10;
      num_digits++;
    end while (magnitude != 0 && num_digits < 10);
    if (negative) begin
      ch.text_char = CharMinus;
      ch.last_char = 1'b0;
      expected_text.push_back(ch);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      ch.text_char = CharZero + CharW'(digits[k]);
      ch.last_char = (k == 0);
      expected_text.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // check the outgoing character before taking a new request
      if (out_i.valid && out_i.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character %0d last %0b", $time,
                   out_i.text_char, out_i.last_char);
          mismatches++;
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (out_i.text_char !== want.text_char) begin
            $display("%0t: text_char expected %0d actual %0d", $time,
                     want.text_char, out_i.text_char);
            mismatches++;
          end
          if (out_i.last_char !== want.last_char) begin
            $display("%0t: last_char expected %0b actual %0b", $time,
                     want.last_char, out_i.last_char);
            mismatches++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        push_decimal_text(in_i.value);
      end
      mismatches_o <= mismatches;
      pending_o    <= expected_text.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the testbench: clock, reset, integer stimulus, character sink and verdict.
`timescale 1ns / 100ps

module testbench;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent;
  bit          long_hold_done;

  i2da_in_if #(.W(32)) in_ch ();
  i2da_out_if          out_ch ();

  int_to_decimal_ascii_core #(.VALUE_WIDTH(32)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  decimal_text_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one integer and hold it until taken, then sometimes idle for a random gap
  task automatic offer_value(input logic signed [31:0] value);
    int unsigned pick;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] random_value();
    longint      magnitude;
    longint      scale;
    int unsigned num_digits;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom;
    if (pick == 7) begin
      if ($urandom_range(0, 1)) return 32'sh7fff_ffff - $urandom_range(0, 20);
      return 32'sh8000_0000 + $urandom_range(0, 20);
    end
    if (pick == 9) return $signed($urandom_range(0, 40)) - 20;
    num_digits = $urandom_range(1, 10);
    scale = 1;
    repeat (num_digits) scale = scale * 10;
    if (pick == 8) begin
      // power of ten, give or take one
      magnitude = scale / 10 + $signed($urandom_range(0, 2)) - 1;
    end else if (num_digits == 10) begin
      magnitude = longint'($urandom_range(1_000_000_000, 2_147_483_647));
    end else begin
      magnitude = scale / 10 + ({32'd0, $urandom} % (scale - scale / 10));
    end
    if (magnitude < 0) magnitude = 0;
    return 32'($urandom_range(0, 1) ? -magnitude : magnitude);
  endfunction

  // Request source
  initial begin
    logic signed [31:0] directed[$];
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    rst_ni      <= 1'b0;
    items_sent  = 0;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, -32'sd9, 32'sh7fff_ffff, 32'sh8000_0000,
                 32'sh8000_0001, 32'sd1_000_000_000, -32'sd1_000_000_000,
                 32'sd999_999_999, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sd1_234_567_890, -32'sd1_234_567_890, 32'sd7,
                 32'sd1_000_000_001, -32'sd99_999};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) offer_value(directed[i]);
    repeat (80) offer_value(random_value());
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Character sink with random back-pressure and one long hold-off
  initial begin
    int unsigned pick;
    out_ch.ready   <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (!long_hold_done && items_sent >= 40) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (pick < 15) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk_i);
      end else if (pick < 60) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (pick < 95) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

endmodule
